[hw/rtl/lpr_pkg.sv]
// Shared types and constants of the literal pattern replace unit.
`default_nettype none
package lpr_pkg;

    localparam int C_MAX_PATTERN     = 8;
    localparam int C_MAX_REPLACEMENT = 8;
    localparam int C_WIN             = 8;
    localparam int C_LEN_W           = 4;
    localparam int C_POS_W           = 3;
    localparam int C_QUEUE_DEPTH     = 2;
    localparam int C_REG_IDX_W       = 2;

    typedef enum logic [C_REG_IDX_W-1:0] {
        REG_PATTERN_BYTES,
        REG_PATTERN_LENGTH,
        REG_REPLACEMENT_BYTES,
        REG_REPLACEMENT_LENGTH
    } t_reg_idx;

    typedef struct packed {
        logic [63:0]        pattern_bytes;
        logic [C_LEN_W-1:0] pattern_length;
        logic [63:0]        replacement_bytes;
        logic [C_LEN_W-1:0] replacement_length;
    } t_cfg;

    // one request's output burst: bytes 0..last_idx are sent in order
    typedef struct packed {
        logic [C_WIN-1:0][7:0] bytes;
        logic [C_POS_W-1:0]    last_idx;
    } t_job;

endpackage
`default_nettype wire

[hw/rtl/literal_pattern_replace_unit.sv]
// Top level of the streaming literal pattern replace unit.
//
// Input channel (i_in_valid / o_in_ready) takes one byte per request with a
// token-end flag. Output channel (o_out_valid / i_out_ready) gives the joined
// text one byte per request; o_run_last marks the last byte caused by an input.
// Configuration channel (i_cfg_valid / o_cfg_ready) writes pattern bytes,
// pattern length, replacement bytes and replacement length, index 0..3; it is
// always ready. It must be written only while the unit is idle; the block
// itself does not enforce this. The front end settles each input byte
// combinationally: the longest held tail that is a pattern prefix is kept,
// earlier bytes or the replacement are queued as one burst. The back end sends
// a burst at one byte per cycle while the receiver is ready. The first output
// byte passes through the burst queue and then the output register. The burst
// queue holds two bursts; input stays ready while it has room, also when the
// receiver stalls. Reset clears the queue, output register, held count and
// configuration (pass-through).
`default_nettype none
module literal_pattern_replace_unit #(
    parameter int P_MAX_PATTERN     = lpr_pkg::C_MAX_PATTERN,
    parameter int P_MAX_REPLACEMENT = lpr_pkg::C_MAX_REPLACEMENT,
    parameter int P_QUEUE_DEPTH     = lpr_pkg::C_QUEUE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [7:0]                      i_data_byte,
    input  logic                            i_token_end,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [7:0]                      o_out_byte,
    output logic                            o_run_last,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [lpr_pkg::C_REG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]                     i_cfg_data
);
    import lpr_pkg::*;

    t_cfg cfg;
    logic clear;
    logic push;
    logic pop;
    logic q_full;
    logic q_empty;
    t_job job;
    t_job head;

    lpr_cfg #(
        .P_MAX_PATTERN     (P_MAX_PATTERN),
        .P_MAX_REPLACEMENT (P_MAX_REPLACEMENT)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg),
        .o_clear     (clear)
    );

    lpr_front #(
        .P_MAX_PATTERN (P_MAX_PATTERN)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_clear     (clear),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_data_byte (i_data_byte),
        .i_token_end (i_token_end),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_job       (job)
    );

    lpr_fifo #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head)
    );

    lpr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_empty),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_run_last  (o_run_last)
    );

endmodule
`default_nettype wire

[hw/rtl/lpr_cfg.sv]
// Configuration register file with length clamping.
`default_nettype none
module lpr_cfg #(
    parameter int P_MAX_PATTERN     = lpr_pkg::C_MAX_PATTERN,
    parameter int P_MAX_REPLACEMENT = lpr_pkg::C_MAX_REPLACEMENT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [lpr_pkg::C_REG_IDX_W-1:0]  i_cfg_index,
    input  logic [63:0]                      i_cfg_data,
    output lpr_pkg::t_cfg                    o_cfg,
    output logic                             o_clear
);
    import lpr_pkg::*;

    t_cfg               r_cfg;
    t_reg_idx           idx;
    logic [C_LEN_W-1:0] wr_len;

    assign o_cfg_ready = 1'b1;
    assign idx         = t_reg_idx'(i_cfg_index);
    assign wr_len      = i_cfg_data[C_LEN_W-1:0];
    assign o_clear     = i_cfg_valid && (idx == REG_PATTERN_LENGTH);
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (idx)
                REG_PATTERN_BYTES: begin
                    r_cfg.pattern_bytes <= i_cfg_data;
                end
                REG_PATTERN_LENGTH: begin
                    r_cfg.pattern_length <= (wr_len > C_LEN_W'(P_MAX_PATTERN)) ?
                                            C_LEN_W'(P_MAX_PATTERN) : wr_len;
                end
                REG_REPLACEMENT_BYTES: begin
                    r_cfg.replacement_bytes <= i_cfg_data;
                end
                REG_REPLACEMENT_LENGTH: begin
                    r_cfg.replacement_length <= (wr_len > C_LEN_W'(P_MAX_REPLACEMENT)) ?
                                                C_LEN_W'(P_MAX_REPLACEMENT) : wr_len;
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

[hw/rtl/lpr_front.sv]
// Front end: accepts bytes, runs the prefix fallback and builds output bursts.
`default_nettype none
module lpr_front #(
    parameter int P_MAX_PATTERN = lpr_pkg::C_MAX_PATTERN
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  lpr_pkg::t_cfg i_cfg,
    input  logic          i_clear,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic [7:0]    i_data_byte,
    input  logic          i_token_end,
    input  logic          i_q_full,
    output logic          o_push,
    output lpr_pkg::t_job o_job
);
    import lpr_pkg::*;

    localparam int CW = $clog2(P_MAX_PATTERN + 1);

    logic [7:0]         r_held [P_MAX_PATTERN];
    logic [7:0]         n_held [P_MAX_PATTERN];
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic [7:0]         win [P_MAX_PATTERN];
    logic [CW-1:0]      win_n;
    logic [CW-1:0]      start;
    logic [CW-1:0]      plen;
    logic [P_MAX_PATTERN-1:0] ok;
    logic               matched;
    logic               accept;
    logic [C_LEN_W-1:0] emit_cnt;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign plen       = CW'(i_cfg.pattern_length);
    assign win_n      = r_count + 1'b1;

    always_comb begin
        for (int i = 0; i < P_MAX_PATTERN; i++) begin
            win[i] = (CW'(i) == r_count) ? i_data_byte : r_held[i];
        end
        // tail starting at i is a prefix of the pattern
        for (int i = 0; i < P_MAX_PATTERN; i++) begin
            ok[i] = 1'b1;
            for (int k = 0; k < P_MAX_PATTERN - i; k++) begin
                if ((i + k < int'(win_n)) && (win[i + k] != i_cfg.pattern_bytes[8*k +: 8])) begin
                    ok[i] = 1'b0;
                end
            end
        end
        start = win_n;
        for (int i = P_MAX_PATTERN - 1; i >= 0; i--) begin
            if ((CW'(i) < win_n) && ok[i]) begin
                start = CW'(i);
            end
        end
        matched = (plen != '0) && (start < win_n) && ((win_n - start) == plen);

        for (int k = 0; k < P_MAX_PATTERN; k++) begin
            n_held[k] = r_held[k];
            for (int s = 0; s < P_MAX_PATTERN - k; s++) begin
                if (CW'(s) == start) begin
                    n_held[k] = win[k + s];
                end
            end
        end
        if ((plen == '0) || matched || i_token_end) begin
            n_count = '0;
        end else begin
            n_count = win_n - start;
        end

        o_job.bytes = '0;
        for (int j = 0; j < P_MAX_PATTERN; j++) begin
            o_job.bytes[j] = win[j];
        end
        if (matched) begin
            o_job.bytes = i_cfg.replacement_bytes;
            emit_cnt    = i_cfg.replacement_length;
        end else if ((plen == '0) || i_token_end) begin
            emit_cnt = C_LEN_W'(win_n);
        end else begin
            emit_cnt = C_LEN_W'(start);
        end
        o_job.last_idx = C_POS_W'(emit_cnt - 1'b1);
    end

    assign o_push = accept && (emit_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_clear) begin
            r_count <= '0;
        end else if (accept) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_held <= n_held;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/lpr_fifo.sv]
// Short burst queue between front and back ends.
`default_nettype none
module lpr_fifo #(
    parameter int P_DEPTH = lpr_pkg::C_QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lpr_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output lpr_pkg::t_job o_head
);
    import lpr_pkg::*;

    localparam int AW = $clog2(P_DEPTH);
    localparam int NW = $clog2(P_DEPTH + 1);

    t_job          r_mem [P_DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [NW-1:0] r_fill;

    assign o_full  = (r_fill == NW'(P_DEPTH));
    assign o_empty = (r_fill == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(P_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(P_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (!i_push && i_pop) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/lpr_back.sv]
// Back end: drains queued bursts into the output register, one byte per cycle while that register is free.
`default_nettype none
module lpr_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  lpr_pkg::t_job i_head,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [7:0]    o_out_byte,
    output logic          o_run_last
);
    import lpr_pkg::*;

    logic [C_POS_W-1:0] r_pos;
    logic               r_out_valid;
    logic [7:0]         r_out_byte;
    logic               r_run_last;
    logic               slot_free;
    logic               load;
    logic               last;

    assign slot_free   = !r_out_valid || i_out_ready;
    assign load        = slot_free && !i_empty;
    assign last        = (r_pos == i_head.last_idx);
    assign o_pop       = load && last;
    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_run_last  = r_run_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pos       <= '0;
        end else begin
            if (slot_free) begin
                r_out_valid <= !i_empty;
            end
            if (load) begin
                r_pos <= last ? '0 : r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_byte <= i_head.bytes[r_pos];
            r_run_last <= last;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/lpr_checker.sv]
// Port-level checker for the literal pattern replace unit, with its bind.
`default_nettype none
module lpr_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       o_in_ready,
    input wire       o_out_valid,
    input wire       i_out_ready,
    input wire [7:0] o_out_byte,
    input wire       o_run_last,
    input wire       o_cfg_ready
);

    // stalled output request keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_out_byte) && $stable(o_run_last))
        else $error("output request changed while stalled");

    // no output right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // a full queue means the output register is occupied
    a_full_backed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with empty output register");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("configuration port not ready");

endmodule

bind literal_pattern_replace_unit lpr_checker u_lpr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_byte  (o_out_byte),
    .o_run_last  (o_run_last),
    .o_cfg_ready (o_cfg_ready)
);
`default_nettype wire

[tb/tb_literal_pattern_replace_unit.sv]
// Testbench for the literal pattern replace unit: directed and random byte streams, self-checking.
`timescale 1ns / 100ps

module tb_literal_pattern_replace_unit;
    import lpr_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 400;

    typedef struct packed {
        logic [7:0] val;
        logic       last;
    } text_rec_t;

    typedef struct packed {
        logic [7:0] data;
        logic       tend;
    } in_rec_t;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_in_valid  = 1'b0;
    logic                   o_in_ready;
    logic [7:0]             i_data_byte = 8'h00;
    logic                   i_token_end = 1'b0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    logic [7:0]             o_out_byte;
    logic                   o_run_last;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [C_REG_IDX_W-1:0] i_cfg_index = '0;
    logic [63:0]            i_cfg_data  = '0;

    literal_pattern_replace_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_data_byte (i_data_byte),
        .i_token_end (i_token_end),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_run_last  (o_run_last),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // shadow of the unit's configuration and partial-match state
    logic [63:0] pat_word = '0;
    int          pat_len  = 0;
    logic [63:0] rep_word = '0;
    int          rep_len  = 0;
    logic [7:0]  held_q [0:7];
    int          held_cnt = 0;

    text_rec_t   expected_text [$];
    in_rec_t     pend_bytes [$];
    in_rec_t     cur;
    logic [7:0]  alpha [0:2];

    int  taken_cnt  = 0;
    int  seen_cnt   = 0;
    int  gap_left   = 0;
    int  burst_left = 0;
    int  cfg_writes = 0;
    int  results_ok = 0;
    int  fail_cnt   = 0;
    int  shown      = 0;
    int  cycles     = 0;
    int  rdy_tick   = 0;
    int  stall_left = 0;
    int  hold_left  = 0;
    bit  hold_done  = 1'b0;
    bit  long_hold_go = 1'b0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    task automatic apply_cfg(input t_reg_idx idx, input logic [63:0] d);
        case (idx)
            REG_PATTERN_BYTES: pat_word = d;
            REG_PATTERN_LENGTH: begin
                pat_len  = (d[3:0] > C_MAX_PATTERN) ? C_MAX_PATTERN : int'(d[3:0]);
                held_cnt = 0;
            end
            REG_REPLACEMENT_BYTES: rep_word = d;
            REG_REPLACEMENT_LENGTH:
                rep_len = (d[3:0] > C_MAX_REPLACEMENT) ? C_MAX_REPLACEMENT : int'(d[3:0]);
            default: ;
        endcase
    endtask

    // leftmost non-overlapping replace with longest-prefix fallback
    task automatic replace_step(input logic [7:0] b, input logic e);
        logic [7:0] win [0:7];
        text_rec_t  burst [$];
        int         n, st, i, k;
        bit         ok;
        if (held_cnt > C_MAX_PATTERN - 1) held_cnt = 0;
        for (i = 0; i < held_cnt; i++) win[i] = held_q[i];
        win[held_cnt] = b;
        n = held_cnt + 1;
        if (pat_len == 0) begin
            for (i = 0; i < n; i++)
                burst.insert(burst.size(), text_rec_t'{val: win[i], last: 1'b0});
            held_cnt = 0;
        end else begin
            st = n;
            for (i = 0; i < n && st == n; i++) begin
                ok = 1'b1;
                for (k = 0; k < n - i; k++)
                    if (win[i + k] != pat_word[8 * k +: 8]) ok = 1'b0;
                if (ok) st = i;
            end
            for (i = 0; i < st; i++)
                burst.insert(burst.size(), text_rec_t'{val: win[i], last: 1'b0});
            if (st < n && n - st == pat_len) begin
                for (k = 0; k < rep_len; k++)
                    burst.insert(burst.size(),
                                 text_rec_t'{val: rep_word[8 * k +: 8], last: 1'b0});
                held_cnt = 0;
            end else begin
                held_cnt = n - st;
                for (k = 0; k < held_cnt; k++) held_q[k] = win[st + k];
            end
        end
        if (e) begin
            for (k = 0; k < held_cnt; k++)
                burst.insert(burst.size(), text_rec_t'{val: held_q[k], last: 1'b0});
            held_cnt = 0;
        end
        if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
        foreach (burst[j]) expected_text.insert(expected_text.size(), burst[j]);
    endtask

    // request acceptance on both input channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                apply_cfg(t_reg_idx'(i_cfg_index), i_cfg_data);
                cfg_writes++;
            end
            if (i_in_valid && o_in_ready) begin
                replace_step(i_data_byte, i_token_end);
                taken_cnt++;
            end
        end
    end

    // input driver: bursts with random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || taken_cnt != seen_cnt) begin
            seen_cnt = taken_cnt;
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pend_bytes.size() > 0) begin
                cur = pend_bytes.pop_front();
                i_data_byte <= cur.data;
                i_token_end <= cur.tend;
                i_in_valid  <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 15);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // output ready: rotating stall pattern plus one long hold-off
    always @(negedge i_clk) begin
        rdy_tick++;
        if (long_hold_go && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            case ((rdy_tick / 97) % 3)
                0: i_out_ready <= 1'b1;
                1: begin
                    if ($urandom_range(0, 3) == 0) begin
                        stall_left = $urandom_range(0, 2);
                        i_out_ready <= 1'b0;
                    end else begin
                        i_out_ready <= 1'b1;
                    end
                end
                default: i_out_ready <= 1'($urandom_range(0, 1));
            endcase
        end
    end

    // output monitor
    always @(posedge i_clk) begin
        text_rec_t exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_text.size() == 0) begin
                fail_cnt++;
                if (shown < 10)
                    $display("unexpected output byte %h last %b", o_out_byte, o_run_last);
                shown++;
            end else begin
                exp_r = expected_text.pop_front();
                if (o_out_byte !== exp_r.val || o_run_last !== exp_r.last) begin
                    fail_cnt++;
                    if (shown < 10)
                        $display("mismatch: expected byte %h last %b, got byte %h last %b",
                                 exp_r.val, exp_r.last, o_out_byte, o_run_last);
                    shown++;
                end else begin
                    results_ok++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results pending", cycles,
                     expected_text.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic cfg_write(input t_reg_idx idx, input logic [63:0] d);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic push_byte(input logic [7:0] b, input logic e);
        pend_bytes.insert(pend_bytes.size(), in_rec_t'{data: b, tend: e});
    endtask

    task automatic wait_idle();
        while (pend_bytes.size() > 0 || i_in_valid || expected_text.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // length register value with random high bits; full length sometimes given as 9..15
    function automatic logic [63:0] len_word(input int want);
        int raw;
        raw = want;
        if (want == 8 && $urandom_range(0, 1) == 1) raw = $urandom_range(9, 15);
        return ({$urandom, $urandom} & 64'hFFFF_FFFF_FFFF_FFF0) | 64'(raw);
    endfunction

    // one token: mostly pattern copies, prefixes and alphabet bytes; some pure noise
    task automatic gen_token(output int cnt);
        logic [7:0] tok [$];
        int         pieces, p, k, cut;
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 10)) tok.insert(tok.size(), 8'($urandom));
        end else begin
            pieces = $urandom_range(1, 4);
            for (p = 0; p < pieces; p++) begin
                case ($urandom_range(0, 3))
                    0, 1: begin
                        if (pat_len > 0)
                            for (k = 0; k < pat_len; k++)
                                tok.insert(tok.size(), pat_word[8 * k +: 8]);
                        else
                            tok.insert(tok.size(), alpha[$urandom_range(0, 2)]);
                    end
                    2: begin
                        cut = (pat_len > 1) ? $urandom_range(1, pat_len - 1) : 1;
                        for (k = 0; k < cut; k++) tok.insert(tok.size(), pat_word[8 * k +: 8]);
                    end
                    default: tok.insert(tok.size(), alpha[$urandom_range(0, 2)]);
                endcase
            end
        end
        foreach (tok[m]) push_byte(tok[m], m == tok.size() - 1);
        cnt = tok.size();
    endtask

    initial begin
        int          ph, want_p, want_r, phase_items, n, k;
        logic [63:0] pw;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // pass-through out of reset
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b1);
        push_byte(8'h5A, 1'b0);
        push_byte(8'hA5, 1'b1);
        wait_idle();

        // "abc" -> "XY": fallback on "aab", match, flush of held bytes at token end
        cfg_write(REG_PATTERN_BYTES, 64'hDEAD_BEEF_0063_6261);
        cfg_write(REG_PATTERN_LENGTH, 64'h3);
        cfg_write(REG_REPLACEMENT_BYTES, 64'h0123_4567_89AB_5958);
        cfg_write(REG_REPLACEMENT_LENGTH, 64'h2);
        push_byte(8'h61, 1'b0);
        push_byte(8'h61, 1'b0);
        push_byte(8'h62, 1'b0);
        push_byte(8'h63, 1'b0);
        push_byte(8'h61, 1'b0);
        push_byte(8'h62, 1'b1);
        wait_idle();

        // pattern bytes changed while bytes are held
        push_byte(8'h61, 1'b0);
        push_byte(8'h62, 1'b0);
        wait_idle();
        cfg_write(REG_PATTERN_BYTES, 64'h0000_0000_0064_6362);
        push_byte(8'h63, 1'b0);
        push_byte(8'h64, 1'b1);
        wait_idle();

        // pattern length write drops held bytes
        push_byte(8'h62, 1'b0);
        push_byte(8'h63, 1'b0);
        wait_idle();
        cfg_write(REG_PATTERN_LENGTH, 64'h3);
        push_byte(8'h64, 1'b1);
        wait_idle();

        // full-length pattern and replacement, lengths given as all ones
        cfg_write(REG_PATTERN_BYTES, 64'hFFFF_FFFF_FFFF_FFFF);
        cfg_write(REG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFFF);
        cfg_write(REG_REPLACEMENT_BYTES, 64'h8877_6655_4433_2211);
        cfg_write(REG_REPLACEMENT_LENGTH, 64'hFFFF_FFFF_FFFF_FFFF);
        for (k = 0; k < 8; k++) push_byte(8'hFF, k == 7);
        wait_idle();

        // empty replacement: a match leaves a step without output
        cfg_write(REG_REPLACEMENT_LENGTH, 64'h0);
        cfg_write(REG_PATTERN_LENGTH, 64'h2);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b1);
        wait_idle();

        for (ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin want_p = 1; want_r = 8; end
                1: begin want_p = 8; want_r = $urandom_range(0, 8); end
                2: begin want_p = 0; want_r = $urandom_range(0, 8); end
                default: begin
                    want_p = $urandom_range(1, 8);
                    want_r = $urandom_range(0, 8);
                end
            endcase
            for (k = 0; k < 3; k++) alpha[k] = 8'($urandom);
            pw = {$urandom, $urandom};
            for (k = 0; k < want_p; k++) pw[8 * k +: 8] = alpha[$urandom_range(0, 2)];
            cfg_write(REG_PATTERN_BYTES, pw);
            cfg_write(REG_REPLACEMENT_BYTES, {$urandom, $urandom});
            cfg_write(REG_PATTERN_LENGTH, len_word(want_p));
            cfg_write(REG_REPLACEMENT_LENGTH, len_word(want_r));
            phase_items = 0;
            while (phase_items < 30) begin
                gen_token(n);
                phase_items += n;
            end
            // pass-through gives the densest output: stall it long here
            if (ph == 2) long_hold_go = 1'b1;
            wait_idle();
        end

        $display("Run: %0d input bytes, %0d output bytes checked, %0d register writes",
                 taken_cnt, results_ok, cfg_writes);
        $display("Covered pass-through, short and full-length patterns, empty and full");
        $display("replacements, mid-token pattern changes and a long output stall");
        if (fail_cnt == 0 && expected_text.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d failures, %0d results never arrived", fail_cnt, expected_text.size());
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/lpr_pkg.sv
hw/rtl/lpr_cfg.sv
hw/rtl/lpr_front.sv
hw/rtl/lpr_fifo.sv
hw/rtl/lpr_back.sv
hw/rtl/literal_pattern_replace_unit.sv
hw/rtl/lpr_checker.sv
tb/tb_literal_pattern_replace_unit.sv
